// ----- rtl/core/bafa_pkg.sv -----
// Package for the block allocator: field widths, reset values, request and
// status codes, and the control state type. No dependencies.
package bafa_pkg;

    localparam int unsigned FREE_DEPTH_DEF = 1024;
    localparam int unsigned BLOCK_BITS_DEF = 32;

    localparam int unsigned BLOCK_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned TOTAL_W  = 32;

    localparam logic [TOTAL_W-1:0] TOTAL_BLOCKS_RST = 32'd1024;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NOSPACE  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP
    } t_state;

endpackage

// ----- rtl/core/bafa_if.sv -----
// Handshake channels of the block allocator: request, response and the
// total_blocks write channel. Depends on bafa_pkg.
interface bafa_req_if;
    logic                         valid;
    logic                         ready;
    bafa_pkg::t_op                opcode;
    logic [bafa_pkg::BLOCK_W-1:0] block_number;

    modport source (output valid, opcode, block_number, input ready);
    modport sink   (input valid, opcode, block_number, output ready);
endinterface

interface bafa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bafa_pkg::BLOCK_W-1:0] allocated_block;
    bafa_pkg::t_status            status;

    modport source (output valid, allocated_block, status, input ready);
    modport sink   (input valid, allocated_block, status, output ready);
endinterface

interface bafa_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [bafa_pkg::TOTAL_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/core/bump_and_free_stack_block_allocator.sv -----
// Block allocator top level: bump pointer backed by a LIFO free stack held in
// a synchronous memory. Depends on bafa_pkg and the channels in bafa_if.
//
// Channel  Dir  Handshake      Payload
// i_req    in   valid/ready    opcode (0 allocate, 1 free), block_number
// o_rsp    out  valid/ready    allocated_block, status
// i_cfg    in   valid/ready    data = total_blocks (always ready)
//
// Sequence: an accepted request moves to S_EXEC, which loads the response
// register once the slot is free; an allocation that must pop goes to S_POP,
// which loads it after the free-stack memory read. i_req.ready is high only
// in S_IDLE, entered as the response loads: one request in flight at a time.
// Reset (i_rst_n low, synchronous): pointer and count to zero, total_blocks
// to 1024. Stalls: a request waits in its own register on o_rsp.ready.
module bump_and_free_stack_block_allocator #(
    parameter int unsigned FREE_DEPTH = bafa_pkg::FREE_DEPTH_DEF,
    parameter int unsigned BLOCK_BITS = bafa_pkg::BLOCK_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bafa_req_if.sink        i_req,
    bafa_rsp_if.source      o_rsp,
    bafa_cfg_if.sink        i_cfg
);

    localparam int unsigned AW    = $clog2(FREE_DEPTH);
    localparam int unsigned CNT_W = $clog2(FREE_DEPTH + 1);

    // Control state
    bafa_pkg::t_state              r_state, n_state;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [BLOCK_BITS-1:0]         r_ptr, n_ptr;
    logic [bafa_pkg::TOTAL_W-1:0]  r_total;
    logic                          r_out_valid, n_out_valid;

    // Held request and response payload
    bafa_pkg::t_op                 r_req_op;
    logic [BLOCK_BITS-1:0]         r_req_blk;
    logic [bafa_pkg::BLOCK_W-1:0]  r_out_block, n_out_block;
    bafa_pkg::t_status             r_out_status, n_out_status;
    logic                          out_load;

    // Free-stack memory
    logic [BLOCK_BITS-1:0]         r_mem [FREE_DEPTH];
    logic [BLOCK_BITS-1:0]         r_rd_data;
    logic                          mem_we, mem_re;
    logic [AW-1:0]                 mem_waddr, mem_raddr;

    logic [bafa_pkg::TOTAL_W-1:0]  limit;
    logic [CNT_W-1:0]              cnt_dec;
    logic [63:0]                   blk_wide, ptr_wide, rd_wide;
    logic                          slot_free, bump_ok;

    assign i_req.ready = (r_state == bafa_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.allocated_block = r_out_block;
    assign o_rsp.status          = r_out_status;

    // Limit wraps within 32 bits: zero total_blocks lets the pointer hand out
    // blocks up to all ones minus one.
    assign limit     = r_total - 32'd1;
    assign ptr_wide  = 64'(r_ptr);
    assign rd_wide   = 64'(r_rd_data);
    assign blk_wide  = 64'(i_req.block_number);
    assign bump_ok   = ptr_wide < 64'(limit);
    assign cnt_dec   = r_count - CNT_W'(1);
    assign slot_free = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ptr        = r_ptr;
        out_load     = 1'b0;
        n_out_block  = r_out_block;
        n_out_status = r_out_status;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = r_count[AW-1:0];
        mem_raddr    = cnt_dec[AW-1:0];

        unique case (r_state)
            bafa_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_state = bafa_pkg::S_EXEC;
                end
            end
            bafa_pkg::S_EXEC: begin
                // Hold until the response register can take a result.
                if (slot_free) begin
                    if (r_req_op == bafa_pkg::OP_ALLOC) begin
                        if (bump_ok) begin
                            out_load     = 1'b1;
                            n_out_block  = ptr_wide[bafa_pkg::BLOCK_W-1:0];
                            n_out_status = bafa_pkg::ST_OK;
                            n_ptr        = r_ptr + BLOCK_BITS'(1);
                            n_state      = bafa_pkg::S_IDLE;
                        end else if (r_count != '0) begin
                            // Pop: read the top entry, respond next cycle.
                            mem_re  = 1'b1;
                            n_count = cnt_dec;
                            n_state = bafa_pkg::S_POP;
                        end else begin
                            out_load     = 1'b1;
                            n_out_block  = '0;
                            n_out_status = bafa_pkg::ST_NOSPACE;
                            n_state      = bafa_pkg::S_IDLE;
                        end
                    end else begin
                        out_load    = 1'b1;
                        n_out_block = '0;
                        n_state     = bafa_pkg::S_IDLE;
                        if (r_count < CNT_W'(FREE_DEPTH)) begin
                            mem_we       = 1'b1;
                            n_count      = r_count + CNT_W'(1);
                            n_out_status = bafa_pkg::ST_OK;
                        end else begin
                            n_out_status = bafa_pkg::ST_OVERFLOW;
                        end
                    end
                end
            end
            bafa_pkg::S_POP: begin
                // Slot was free in S_EXEC and only this block fills it.
                out_load     = 1'b1;
                n_out_block  = rd_wide[bafa_pkg::BLOCK_W-1:0];
                n_out_status = bafa_pkg::ST_OK;
                n_state      = bafa_pkg::S_IDLE;
            end
            default: begin
                n_state = bafa_pkg::S_IDLE;
            end
        endcase

        n_out_valid = out_load || (r_out_valid && !o_rsp.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bafa_pkg::S_IDLE;
            r_count     <= '0;
            r_ptr       <= '0;
            r_total     <= bafa_pkg::TOTAL_BLOCKS_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_total <= i_cfg.data;
            end
        end
    end

    // Request and response payload
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req_op  <= i_req.opcode;
            r_req_blk <= blk_wide[BLOCK_BITS-1:0];
        end
        if (out_load) begin
            r_out_block  <= n_out_block;
            r_out_status <= n_out_status;
        end
    end

    // Free-stack memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= r_req_blk;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

endmodule

// ----- rtl/core/bafa_chk.sv -----
// Port-level checker for the block allocator and its bind onto the top level.
// Depends on bafa_pkg and bump_and_free_stack_block_allocator.
module bafa_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_req_valid,
    input logic                         i_req_ready,
    input logic                         i_rsp_valid,
    input logic                         i_rsp_ready,
    input logic [bafa_pkg::BLOCK_W-1:0] i_rsp_block,
    input bafa_pkg::t_status            i_rsp_status
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> $stable(i_rsp_block) && $stable(i_rsp_status))
        else $error("response payload changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("second request taken while one is in flight");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_status != bafa_pkg::ST_OK |-> i_rsp_block == '0)
        else $error("failed request returned a nonzero block");

endmodule

bind bump_and_free_stack_block_allocator bafa_chk u_bafa_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_block  (o_rsp.allocated_block),
    .i_rsp_status (o_rsp.status)
);

// ----- tb/bump_and_free_stack_block_allocator_tb.sv -----
// Self-checking testbench for the bump-pointer block allocator with LIFO free stack.
// Depends on bafa_pkg, the channel interfaces in bafa_if and the allocator top level.
module bump_and_free_stack_block_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // A directed row is either a request or a total_blocks write.
    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind                    kind;
        bafa_pkg::t_op                op;
        logic [bafa_pkg::BLOCK_W-1:0] value;       // freed block, or total_blocks
        logic                         pinned;      // expected response typed in below
        logic [bafa_pkg::BLOCK_W-1:0] want_block;
        bafa_pkg::t_status            want_status;
    } t_step_row;

    typedef struct packed {
        logic [bafa_pkg::BLOCK_W-1:0] block;
        bafa_pkg::t_status            status;
    } t_grant;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bafa_req_if req_ch ();
    bafa_rsp_if rsp_ch ();
    bafa_cfg_if cfg_ch ();

    bump_and_free_stack_block_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    // Mirror of the allocator state, advanced once per accepted request.
    logic [bafa_pkg::TOTAL_W-1:0] mirror_total;
    logic [bafa_pkg::BLOCK_W-1:0] mirror_bump;
    logic [bafa_pkg::BLOCK_W-1:0] mirror_stack [bafa_pkg::FREE_DEPTH_DEF];
    int unsigned                  mirror_depth;

    // Responses owed by the block, oldest first.
    t_grant                       owed_responses [$];
    // Recently handed-out blocks, reused as realistic free requests.
    logic [bafa_pkg::BLOCK_W-1:0] recent_grants [$];

    int unsigned fault_count = 0;
    bit          calm = 1'b0;       // no idling on either side while set

    // Directed part. Rows with pinned = 1 carry an expectation read straight
    // off the allocator rules; the rest go through the mirror.
    t_step_row directed_steps [25] = '{
        // fresh after reset: bump pointer hands out 0 then 1, block_number ignored
        '{ROW_REQ, bafa_pkg::OP_ALLOC, 32'h0000_0000, 1'b1, 32'd0, bafa_pkg::ST_OK},
        '{ROW_REQ, bafa_pkg::OP_ALLOC, 32'hFFFF_FFFF, 1'b1, 32'd1, bafa_pkg::ST_OK},
        // frees of the extreme block numbers
        '{ROW_REQ, bafa_pkg::OP_FREE,  32'hFFFF_FFFF, 1'b1, 32'd0, bafa_pkg::ST_OK},
        '{ROW_REQ, bafa_pkg::OP_FREE,  32'h0000_0000, 1'b1, 32'd0, bafa_pkg::ST_OK},
        // shrink the device below the pointer: bump allocation stops, LIFO pops
        '{ROW_CFG, bafa_pkg::OP_ALLOC, 32'd2,         1'b0, 32'd0, bafa_pkg::ST_OK},
        '{ROW_REQ, bafa_pkg::OP_ALLOC, 32'h0000_0000, 1'b1, 32'd0, bafa_pkg::ST_OK},
        '{ROW_REQ, bafa_pkg::OP_ALLOC, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF,
          bafa_pkg::ST_OK},
        // empty stack with a spent pointer
        '{ROW_REQ, bafa_pkg::OP_ALLOC, 32'h0000_0000, 1'b1, 32'd0, bafa_pkg::ST_NOSPACE},
        // double free of a block beyond the device
        '{ROW_REQ, bafa_pkg::OP_FREE,  32'h1234_5678, 1'b1, 32'd0, bafa_pkg::ST_OK},
        '{ROW_REQ, bafa_pkg::OP_FREE,  32'h1234_5678, 1'b1, 32'd0, bafa_pkg::ST_OK},
        '{ROW_REQ, bafa_pkg::OP_ALLOC, 32'h0000_0000, 1'b0, 32'd0, bafa_pkg::ST_OK},
        // single block device serves only freed blocks
        '{ROW_CFG, bafa_pkg::OP_ALLOC, 32'd1,         1'b0, 32'd0, bafa_pkg::ST_OK},
        '{ROW_REQ, bafa_pkg::OP_ALLOC, 32'h0000_0000, 1'b0, 32'd0, bafa_pkg::ST_OK},
        '{ROW_REQ, bafa_pkg::OP_ALLOC, 32'h0000_0000, 1'b1, 32'd0, bafa_pkg::ST_NOSPACE},
        // zero total_blocks: limit wraps to all ones, pointer resumes where it was
        '{ROW_CFG, bafa_pkg::OP_ALLOC, 32'd0,         1'b0, 32'd0, bafa_pkg::ST_OK},
        '{ROW_REQ, bafa_pkg::OP_ALLOC, 32'h5A5A_5A5A, 1'b1, 32'd2, bafa_pkg::ST_OK},
        '{ROW_REQ, bafa_pkg::OP_ALLOC, 32'h0000_0000, 1'b0, 32'd0, bafa_pkg::ST_OK},
        '{ROW_CFG, bafa_pkg::OP_ALLOC, 32'hFFFF_FFFF, 1'b0, 32'd0, bafa_pkg::ST_OK},
        '{ROW_REQ, bafa_pkg::OP_ALLOC, 32'h0000_0000, 1'b0, 32'd0, bafa_pkg::ST_OK},
        '{ROW_REQ, bafa_pkg::OP_FREE,  32'hAAAA_AAAA, 1'b1, 32'd0, bafa_pkg::ST_OK},
        '{ROW_REQ, bafa_pkg::OP_FREE,  32'h5555_5555, 1'b0, 32'd0, bafa_pkg::ST_OK},
        // shrink again: the two frees come back newest first
        '{ROW_CFG, bafa_pkg::OP_ALLOC, 32'd4,         1'b0, 32'd0, bafa_pkg::ST_OK},
        '{ROW_REQ, bafa_pkg::OP_ALLOC, 32'h0000_0000, 1'b0, 32'd0, bafa_pkg::ST_OK},
        '{ROW_REQ, bafa_pkg::OP_ALLOC, 32'h0000_0000, 1'b0, 32'd0, bafa_pkg::ST_OK},
        '{ROW_REQ, bafa_pkg::OP_ALLOC, 32'h0000_0000, 1'b1, 32'd0, bafa_pkg::ST_NOSPACE}
    };

    // Work out the response to one request and advance the mirror.
    function automatic t_grant allocate_or_free(bafa_pkg::t_op op,
                                                logic [bafa_pkg::BLOCK_W-1:0] blk);
        t_grant                       outcome;
        logic [bafa_pkg::BLOCK_W-1:0] bump_limit;
        outcome.block  = '0;
        outcome.status = bafa_pkg::ST_OK;
        // limit wraps to all ones when total_blocks is zero
        bump_limit = mirror_total - 1'b1;
        if (op == bafa_pkg::OP_ALLOC) begin
            if (mirror_bump < bump_limit) begin
                outcome.block = mirror_bump;
                mirror_bump   = mirror_bump + 1'b1;
            end else if (mirror_depth != 0) begin
                mirror_depth  = mirror_depth - 1;
                outcome.block = mirror_stack[mirror_depth];
            end else begin
                outcome.status = bafa_pkg::ST_NOSPACE;
            end
            if (outcome.status == bafa_pkg::ST_OK) begin
                recent_grants.push_back(outcome.block);
                if (recent_grants.size() > 64) void'(recent_grants.pop_front());
            end
        end else if (mirror_depth < bafa_pkg::FREE_DEPTH_DEF) begin
            mirror_stack[mirror_depth] = blk;
            mirror_depth = mirror_depth + 1;
        end else begin
            // full stack: drop the push, flag it
            outcome.status = bafa_pkg::ST_OVERFLOW;
        end
        return outcome;
    endfunction

    // Idle length: mostly none, sometimes short, rarely long.
    function automatic int unsigned idle_span();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 65) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Free requests: mostly blocks handed out earlier, plus arbitrary numbers.
    function automatic logic [bafa_pkg::BLOCK_W-1:0] pick_freed_block();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45 && recent_grants.size() != 0)
            return recent_grants[$urandom_range(0, recent_grants.size() - 1)];
        if (roll < 55) return '0;
        if (roll < 62) return '1;
        if (roll < 70) return 32'd1 << $urandom_range(0, bafa_pkg::BLOCK_W - 1);
        if (roll < 80) return $urandom_range(0, 2048);
        return $urandom();
    endfunction

    // Offer one request, hold it until accepted, then record what it owes.
    // Called and returns at a falling edge; valid stays high for the caller.
    task automatic issue_request(input bafa_pkg::t_op op,
                                 input logic [bafa_pkg::BLOCK_W-1:0] blk,
                                 input logic pinned,
                                 input logic [bafa_pkg::BLOCK_W-1:0] want_block,
                                 input bafa_pkg::t_status want_status);
        t_grant outcome;
        req_ch.valid        <= 1'b1;
        req_ch.opcode       <= op;
        req_ch.block_number <= blk;
        do @(posedge i_clk); while (!req_ch.ready);
        outcome = allocate_or_free(op, blk);
        if (pinned) begin
            outcome.block  = want_block;
            outcome.status = want_status;
        end
        owed_responses.push_back(outcome);
        @(negedge i_clk);
    endtask

    // Drop valid and hold until every owed response has been taken.
    task automatic wait_all_answered();
        req_ch.valid <= 1'b0;
        do @(negedge i_clk); while (owed_responses.size() != 0);
    endtask

    // Insert a random gap after a request.
    task automatic pace_sender();
        int unsigned gap;
        gap = idle_span();
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Write total_blocks once the block is idle.
    task automatic write_total_blocks(input logic [bafa_pkg::TOTAL_W-1:0] total);
        wait_all_answered();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= total;
        do @(posedge i_clk); while (!cfg_ch.ready);
        mirror_total = total;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // One random phase: set the device size, then a mix of allocates and frees.
    task automatic run_phase(input logic [bafa_pkg::TOTAL_W-1:0] total,
                             input int unsigned count,
                             input int unsigned free_pct);
        bafa_pkg::t_op                op;
        logic [bafa_pkg::BLOCK_W-1:0] blk;
        write_total_blocks(total);
        calm = ($urandom_range(0, 3) == 0);
        repeat (count) begin
            if ($urandom_range(0, 99) < free_pct) begin
                op  = bafa_pkg::OP_FREE;
                blk = pick_freed_block();
            end else begin
                op  = bafa_pkg::OP_ALLOC;
                blk = $urandom();
            end
            issue_request(op, blk, 1'b0, '0, bafa_pkg::ST_OK);
            // now and then, hold off until everything has come back
            if ($urandom_range(0, 59) == 0) wait_all_answered();
            else pace_sender();
        end
        calm = 1'b0;
    endtask

    // Compare each accepted response with the oldest owed one.
    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (owed_responses.size() == 0) begin
                $error("unexpected response: allocated_block=%h status=%0d",
                       rsp_ch.allocated_block, rsp_ch.status);
                fault_count++;
            end else begin
                want = owed_responses.pop_front();
                if (rsp_ch.allocated_block !== want.block) begin
                    $error("allocated_block: expected %h, got %h",
                           want.block, rsp_ch.allocated_block);
                    fault_count++;
                end
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    fault_count++;
                end
            end
        end
    end

    // Response side: random back-pressure, none while calm.
    initial begin
        int unsigned hold;
        hold         = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold != 0) begin
                rsp_ch.ready <= 1'b0;
                hold--;
            end else begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) hold = idle_span();
            end
        end
    end

    // Stimulus: reset, directed table, random phases, then drain and report.
    initial begin
        i_rst_n             = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.opcode       = bafa_pkg::OP_ALLOC;
        req_ch.block_number = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.data         = '0;

        mirror_total = bafa_pkg::TOTAL_BLOCKS_RST;
        mirror_bump  = '0;
        mirror_depth = 0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_steps[i]) begin
            if (directed_steps[i].kind == ROW_CFG) begin
                write_total_blocks(directed_steps[i].value);
            end else begin
                issue_request(directed_steps[i].op, directed_steps[i].value,
                              directed_steps[i].pinned, directed_steps[i].want_block,
                              directed_steps[i].want_status);
                pace_sender();
            end
        end

        // Small device first, so the stack gets exercised early.
        run_phase(32'd16, 100, 40);
        run_phase(32'd1, 100, 50);
        run_phase(32'd0, 80, 30);
        run_phase($urandom_range(32, 300), 120, 45);
        // shrink below the pointer, which never rewinds
        run_phase(32'd8, 120, 50);
        run_phase(32'hFFFF_FFFF, 80, 20);
        run_phase(bafa_pkg::TOTAL_BLOCKS_RST, 150, 45);
        // pile up frees on a spent pointer, then pop them back in LIFO order
        run_phase(32'd1, 100, 100);
        run_phase(32'd1, 80, 40);

        wait_all_answered();
        // let any stray response show up
        repeat (12) @(posedge i_clk);

        if (fault_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #(10_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/bafa_pkg.sv
rtl/core/bafa_if.sv
rtl/core/bump_and_free_stack_block_allocator.sv
rtl/core/bafa_chk.sv
tb/bump_and_free_stack_block_allocator_tb.sv
